[hw/rtl/sit_pkg.sv]
// Shared constants for the segment intersection test pipeline.
package sit_pkg;

  // Growth of a signed value through one subtraction.
  localparam int SUB_GROW = 1;

  // Supported range of the coordinate width.
  localparam int COORD_BITS_MIN = 8;
  localparam int COORD_BITS_MAX = 24;

  // Register stages from request to result.
  localparam int PIPE_DEPTH = 4;

endpackage

[hw/rtl/segment_intersection_test.sv]
// Top level of the segment intersection test pipeline.
// Takes one segment pair per clock while busy is low and returns one crossing
// flag per pair, in order, once the request has passed the difference, multiply,
// subtract and compare stages. A request is taken when start is high and busy
// is low; busy is high only while rst_n is asserted. The result is shown on
// out_segments_cross for one cycle, marked by out_valid, and the receiver
// cannot stall it. Parallel and collinear pairs report no crossing; touching
// at an end point reports a crossing.
module segment_intersection_test import sit_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_seg1_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg1_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg1_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg1_end_y,
  input  logic signed [COORD_BITS-1:0] in_seg2_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg2_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg2_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg2_end_y,
  output logic                         out_valid,
  output logic                         out_segments_cross
);

  localparam int DW = COORD_BITS + SUB_GROW;
  localparam int NW = 2 * DW + SUB_GROW;

  logic                 req_acc;
  logic                 s1_valid, s3_valid;
  logic signed [DW-1:0] d1x, d1y, d2x, d2y, wx, wy;
  logic signed [NW-1:0] det, tnum, unum;

  assign busy    = !rst_n;
  assign req_acc = start && !busy;

  sit_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (req_acc),
    .x1_i    (in_seg1_start_x),
    .y1_i    (in_seg1_start_y),
    .x2_i    (in_seg1_end_x),
    .y2_i    (in_seg1_end_y),
    .x3_i    (in_seg2_start_x),
    .y3_i    (in_seg2_start_y),
    .x4_i    (in_seg2_end_x),
    .y4_i    (in_seg2_end_y),
    .valid_o (s1_valid),
    .d1x_o   (d1x),
    .d1y_o   (d1y),
    .d2x_o   (d2x),
    .d2y_o   (d2y),
    .wx_o    (wx),
    .wy_o    (wy)
  );

  sit_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .d1x_i   (d1x),
    .d1y_i   (d1y),
    .d2x_i   (d2x),
    .d2y_i   (d2y),
    .wx_i    (wx),
    .wy_i    (wy),
    .valid_o (s3_valid),
    .det_o   (det),
    .tnum_o  (tnum),
    .unum_o  (unum)
  );

  sit_test #(.COORD_BITS(COORD_BITS)) u_test (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s3_valid),
    .det_i   (det),
    .tnum_i  (tnum),
    .unum_i  (unum),
    .valid_o (out_valid),
    .cross_o (out_segments_cross)
  );

  // a result strobe only follows a request, after the PIPE_DEPTH register stages
  a_latency_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(req_acc, PIPE_DEPTH))
    else $error("result strobe without matching request");

  // every request yields its result after the PIPE_DEPTH register stages
  a_latency_req: assert property (@(posedge clk) disable iff (!rst_n)
    $past(req_acc, PIPE_DEPTH) |-> out_valid)
    else $error("request lost in pipeline");

  a_width_range: assert property (@(posedge clk)
    COORD_BITS >= COORD_BITS_MIN && COORD_BITS <= COORD_BITS_MAX)
    else $error("coordinate width out of supported range");

endmodule

[hw/rtl/sit_diff.sv]
// Stage 1: direction and offset vectors of the two segments.
module sit_diff import sit_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 valid_i,
  input  logic signed [COORD_BITS-1:0]         x1_i,
  input  logic signed [COORD_BITS-1:0]         y1_i,
  input  logic signed [COORD_BITS-1:0]         x2_i,
  input  logic signed [COORD_BITS-1:0]         y2_i,
  input  logic signed [COORD_BITS-1:0]         x3_i,
  input  logic signed [COORD_BITS-1:0]         y3_i,
  input  logic signed [COORD_BITS-1:0]         x4_i,
  input  logic signed [COORD_BITS-1:0]         y4_i,
  output logic                                 valid_o,
  output logic signed [COORD_BITS+SUB_GROW-1:0] d1x_o,
  output logic signed [COORD_BITS+SUB_GROW-1:0] d1y_o,
  output logic signed [COORD_BITS+SUB_GROW-1:0] d2x_o,
  output logic signed [COORD_BITS+SUB_GROW-1:0] d2y_o,
  output logic signed [COORD_BITS+SUB_GROW-1:0] wx_o,
  output logic signed [COORD_BITS+SUB_GROW-1:0] wy_o
);

  localparam int DW = COORD_BITS + SUB_GROW;

  logic                 valid_r;
  logic signed [DW-1:0] d1x_r, d1y_r, d2x_r, d2y_r, wx_r, wy_r;
  logic signed [DW-1:0] d1x_nxt, d1y_nxt, d2x_nxt, d2y_nxt, wx_nxt, wy_nxt;

  always_comb begin
    d1x_nxt = DW'(x2_i) - DW'(x1_i);
    d1y_nxt = DW'(y2_i) - DW'(y1_i);
    d2x_nxt = DW'(x4_i) - DW'(x3_i);
    d2y_nxt = DW'(y4_i) - DW'(y3_i);
    wx_nxt  = DW'(x3_i) - DW'(x1_i);
    wy_nxt  = DW'(y3_i) - DW'(y1_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    d1x_r <= d1x_nxt;
    d1y_r <= d1y_nxt;
    d2x_r <= d2x_nxt;
    d2y_r <= d2y_nxt;
    wx_r  <= wx_nxt;
    wy_r  <= wy_nxt;
  end

  assign valid_o = valid_r;
  assign d1x_o   = d1x_r;
  assign d1y_o   = d1y_r;
  assign d2x_o   = d2x_r;
  assign d2y_o   = d2y_r;
  assign wx_o    = wx_r;
  assign wy_o    = wy_r;

endmodule

[hw/rtl/sit_cross.sv]
// Stages 2 and 3: cross products, then determinant and line-parameter numerators.
module sit_cross import sit_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            valid_i,
  input  logic signed [COORD_BITS+SUB_GROW-1:0]           d1x_i,
  input  logic signed [COORD_BITS+SUB_GROW-1:0]           d1y_i,
  input  logic signed [COORD_BITS+SUB_GROW-1:0]           d2x_i,
  input  logic signed [COORD_BITS+SUB_GROW-1:0]           d2y_i,
  input  logic signed [COORD_BITS+SUB_GROW-1:0]           wx_i,
  input  logic signed [COORD_BITS+SUB_GROW-1:0]           wy_i,
  output logic                                            valid_o,
  output logic signed [2*(COORD_BITS+SUB_GROW)+SUB_GROW-1:0] det_o,
  output logic signed [2*(COORD_BITS+SUB_GROW)+SUB_GROW-1:0] tnum_o,
  output logic signed [2*(COORD_BITS+SUB_GROW)+SUB_GROW-1:0] unum_o
);

  localparam int DW = COORD_BITS + SUB_GROW;
  localparam int PW = 2 * DW;
  localparam int NW = PW + SUB_GROW;

  // product stage
  logic                 pvalid_r;
  logic signed [PW-1:0] pda_r, pdb_r, pta_r, ptb_r, pua_r, pub_r;
  logic signed [PW-1:0] pda_nxt, pdb_nxt, pta_nxt, ptb_nxt, pua_nxt, pub_nxt;

  // difference stage
  logic                 valid_r;
  logic signed [NW-1:0] det_r, tnum_r, unum_r;
  logic signed [NW-1:0] det_nxt, tnum_nxt, unum_nxt;

  always_comb begin
    pda_nxt = PW'(d1x_i) * PW'(d2y_i);
    pdb_nxt = PW'(d1y_i) * PW'(d2x_i);
    pta_nxt = PW'(wx_i) * PW'(d2y_i);
    ptb_nxt = PW'(wy_i) * PW'(d2x_i);
    pua_nxt = PW'(wx_i) * PW'(d1y_i);
    pub_nxt = PW'(wy_i) * PW'(d1x_i);
  end

  always_comb begin
    det_nxt  = NW'(pda_r) - NW'(pdb_r);
    tnum_nxt = NW'(pta_r) - NW'(ptb_r);
    unum_nxt = NW'(pua_r) - NW'(pub_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      pvalid_r <= valid_i;
      valid_r  <= pvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    pda_r  <= pda_nxt;
    pdb_r  <= pdb_nxt;
    pta_r  <= pta_nxt;
    ptb_r  <= ptb_nxt;
    pua_r  <= pua_nxt;
    pub_r  <= pub_nxt;
    det_r  <= det_nxt;
    tnum_r <= tnum_nxt;
    unum_r <= unum_nxt;
  end

  assign valid_o = valid_r;
  assign det_o   = det_r;
  assign tnum_o  = tnum_r;
  assign unum_o  = unum_r;

endmodule

[hw/rtl/sit_test.sv]
// Stage 4: inclusive range test of both line parameters against [0, 1].
module sit_test import sit_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               valid_i,
  input  logic signed [2*(COORD_BITS+SUB_GROW)+SUB_GROW-1:0] det_i,
  input  logic signed [2*(COORD_BITS+SUB_GROW)+SUB_GROW-1:0] tnum_i,
  input  logic signed [2*(COORD_BITS+SUB_GROW)+SUB_GROW-1:0] unum_i,
  output logic                                               valid_o,
  output logic                                               cross_o
);

  localparam int NW = 2 * (COORD_BITS + SUB_GROW) + SUB_GROW;

  logic valid_r, cross_r;
  logic cross_nxt;
  logic det_pos, det_zero, t_in, u_in;

  // num/den in [0, 1]; sense flips for a negative determinant
  always_comb begin
    det_zero = (det_i == NW'(0));
    det_pos  = !det_i[NW-1] && !det_zero;
    if (det_pos) begin
      t_in = !tnum_i[NW-1] && (tnum_i <= det_i);
      u_in = !unum_i[NW-1] && (unum_i <= det_i);
    end else begin
      t_in = (tnum_i <= NW'(0)) && (tnum_i >= det_i);
      u_in = (unum_i <= NW'(0)) && (unum_i >= det_i);
    end
    cross_nxt = valid_i && !det_zero && t_in && u_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cross_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
      cross_r <= cross_nxt;
    end
  end

  assign valid_o = valid_r;
  assign cross_o = cross_r;

  // parallel pairs never report a crossing
  a_cross_needs_det: assert property (@(posedge clk) disable iff (!rst_n)
    cross_r |-> $past(det_i != NW'(0)))
    else $error("crossing reported for zero determinant");

  // a crossing only rides on a valid result
  a_cross_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cross_r |-> valid_r)
    else $error("crossing flag without valid result");

endmodule

[tb/segment_intersection_test_tb.sv]
// Self-checking testbench for the segment intersection test pipeline.
`timescale 1ns / 1ps

module segment_intersection_test_tb;
  import sit_pkg::*;

  localparam int CW          = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOW_MAX    = 10;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t s1x, s1y, e1x, e1y;
    coord_t s2x, s2y, e2x, e2y;
  } seg_pair_t;

  typedef struct {
    int idx;
    bit hit;
  } cross_exp_t;

  typedef enum int {GEN_UNIFORM, GEN_EXTREME, GEN_GRID} pair_gen_t;

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  coord_t in_seg1_start_x, in_seg1_start_y, in_seg1_end_x, in_seg1_end_y;
  coord_t in_seg2_start_x, in_seg2_start_y, in_seg2_end_x, in_seg2_end_y;
  logic   out_valid;
  logic   out_segments_cross;

  cross_exp_t cross_expected[$];
  cross_exp_t cross_head;
  int         errors      = 0;
  int         sent        = 0;
  int         cycle_count = 0;
  bit         burst       = 1'b0;

  segment_intersection_test #(.COORD_BITS(CW)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_seg1_start_x   (in_seg1_start_x),
    .in_seg1_start_y   (in_seg1_start_y),
    .in_seg1_end_x     (in_seg1_end_x),
    .in_seg1_end_y     (in_seg1_end_y),
    .in_seg2_start_x   (in_seg2_start_x),
    .in_seg2_start_y   (in_seg2_start_y),
    .in_seg2_end_x     (in_seg2_end_x),
    .in_seg2_end_y     (in_seg2_end_y),
    .out_valid         (out_valid),
    .out_segments_cross(out_segments_cross)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Inclusive 0 <= num/den <= 1, den nonzero; sense flips for negative den.
  function automatic bit param_in_unit(longint num, longint den);
    if (den > 0) return num >= 0 && num <= den;
    return num <= 0 && num >= den;
  endfunction

  function automatic bit pair_crosses(seg_pair_t p);
    longint d1x, d1y, d2x, d2y, wx, wy, det, tnum, unum;
    d1x = longint'(p.e1x) - longint'(p.s1x);
    d1y = longint'(p.e1y) - longint'(p.s1y);
    d2x = longint'(p.e2x) - longint'(p.s2x);
    d2y = longint'(p.e2y) - longint'(p.s2y);
    wx  = longint'(p.s2x) - longint'(p.s1x);
    wy  = longint'(p.s2y) - longint'(p.s1y);
    det = d1x * d2y - d1y * d2x;
    // parallel, collinear and degenerate pairs never cross
    if (det == 0) return 1'b0;
    tnum = wx * d2y - wy * d2x;
    unum = wx * d1y - wy * d1x;
    return param_in_unit(tnum, det) && param_in_unit(unum, det);
  endfunction

  function automatic seg_pair_t mk_pair(int ax, int ay, int bx, int by,
                                        int cx, int cy, int dx, int dy);
    seg_pair_t p;
    p.s1x = coord_t'(ax); p.s1y = coord_t'(ay);
    p.e1x = coord_t'(bx); p.e1y = coord_t'(by);
    p.s2x = coord_t'(cx); p.s2y = coord_t'(cy);
    p.e2x = coord_t'(dx); p.e2y = coord_t'(dy);
    return p;
  endfunction

  function automatic coord_t rand_coord(pair_gen_t gen, int base);
    logic [CW-1:0] r;
    r = CW'($urandom);
    if (gen == GEN_GRID) return coord_t'(base + $urandom_range(0, 8));
    if (gen == GEN_EXTREME) begin
      case ($urandom_range(0, 7))
        0: return coord_t'(-32768);
        1: return coord_t'(-32767);
        2: return coord_t'(-1);
        3: return coord_t'(0);
        4: return coord_t'(1);
        5: return coord_t'(32766);
        6: return coord_t'(32767);
        default: return r;
      endcase
    end
    return r;
  endfunction

  function automatic seg_pair_t rand_pair(pair_gen_t gen);
    seg_pair_t p;
    int bx, by;
    // small grids make touching, parallel and collinear pairs common
    bx = int'($urandom_range(0, 65535 - 8)) - 32768;
    by = int'($urandom_range(0, 65535 - 8)) - 32768;
    p.s1x = rand_coord(gen, bx); p.s1y = rand_coord(gen, by);
    p.e1x = rand_coord(gen, bx); p.e1y = rand_coord(gen, by);
    p.s2x = rand_coord(gen, bx); p.s2y = rand_coord(gen, by);
    p.e2x = rand_coord(gen, bx); p.e2y = rand_coord(gen, by);
    return p;
  endfunction

  task automatic send_pair(seg_pair_t p);
    int gap;
    cross_exp_t exp_item;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_seg1_start_x <= p.s1x;
    in_seg1_start_y <= p.s1y;
    in_seg1_end_x   <= p.e1x;
    in_seg1_end_y   <= p.e1y;
    in_seg2_start_x <= p.s2x;
    in_seg2_start_y <= p.s2y;
    in_seg2_end_x   <= p.e2x;
    in_seg2_end_y   <= p.e2y;
    @(posedge clk);
    while (busy) @(posedge clk);
    exp_item = '{idx: sent, hit: pair_crosses(p)};
    cross_expected = {cross_expected, exp_item};
    sent++;
  endtask

  // hold requests off until every outstanding result is back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (cross_expected.size() != 0);
  endtask

  task automatic run_random(pair_gen_t gen, int count);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      send_pair(rand_pair(gen));
    end
    burst = 1'b0;
  endtask

  task automatic test_directed();
    send_pair(mk_pair(0, 0, 10, 10, 0, 10, 10, 0));          // plain X
    send_pair(mk_pair(0, 0, 1, 1, 5, 5, 6, 7));              // boxes apart
    send_pair(mk_pair(0, 0, 4, 0, 0, 1, 4, 1));              // parallel
    send_pair(mk_pair(0, 0, 4, 4, 2, 2, 6, 6));              // collinear overlap
    send_pair(mk_pair(3, 3, 3, 3, 0, 0, 6, 6));              // seg1 is a point
    send_pair(mk_pair(0, 0, 6, 6, 3, 3, 3, 3));              // seg2 is a point
    send_pair(mk_pair(2, 2, 2, 2, 2, 2, 2, 2));              // both points
    send_pair(mk_pair(0, 0, 4, 0, 4, 0, 4, 5));              // end to end
    send_pair(mk_pair(0, 0, 4, 0, 4, 5, 4, 0));              // end to end, det < 0
    send_pair(mk_pair(0, 0, 4, 0, 2, 0, 2, 5));              // T touch
    send_pair(mk_pair(0, 0, 5, 1, 0, 0, 1, 5));              // shared start
    send_pair(mk_pair(0, 0, 4, 0, 2, 1, 2, 5));              // near miss
    send_pair(mk_pair(4, 0, 0, 0, 2, 1, 2, 5));              // near miss, det < 0
    send_pair(mk_pair(0, 0, 4, 4, 0, 3, 1, 2));              // boxes meet, lines miss
    send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(mk_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_pair(mk_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, -32767, 32766, 32767));
    send_pair(mk_pair(-32768, -32768, 32767, -32767, 0, -32768, 1, 32767));
    send_pair(mk_pair(-32768, 32767, 32767, 32767, 32767, -32768, 32767, 32767));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    send_pair(mk_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
  endtask

  task automatic test_uniform();
    run_random(GEN_UNIFORM, 800);
  endtask

  task automatic test_extremes();
    run_random(GEN_EXTREME, 400);
  endtask

  task automatic test_small_grid();
    run_random(GEN_GRID, 660);
  endtask

  task automatic test_drain_pause();
    run_random(GEN_GRID, 35);
    wait_drained();
    run_random(GEN_UNIFORM, 35);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** segment_intersection_test: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (cross_expected.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("unexpected result: cross=%b with no request pending", out_segments_cross);
      end else begin
        cross_head = cross_expected.pop_front();
        if (out_segments_cross !== cross_head.hit) begin
          errors++;
          if (errors <= SHOW_MAX)
            $display("request %0d: segments_cross expected %b, got %b",
                     cross_head.idx, cross_head.hit, out_segments_cross);
        end
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_seg1_start_x <= '0;
    in_seg1_start_y <= '0;
    in_seg1_end_x   <= '0;
    in_seg1_end_y   <= '0;
    in_seg2_start_x <= '0;
    in_seg2_start_y <= '0;
    in_seg2_end_x   <= '0;
    in_seg2_end_y   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_uniform();
    test_extremes();
    test_drain_pause();
    test_small_grid();

    wait_drained();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (errors == 0 && cross_expected.size() == 0) begin
      $display("** segment_intersection_test: PASSED **");
    end else begin
      $display("** segment_intersection_test: FAILED **");
    end
    $finish;
  end

endmodule
